@@ rtl/core/pwt_pkg.sv @@
// Package for the Prewitt edge threshold block: payload structs, widths,
// register indexes and the edge level. No dependencies.
package pwt_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = 10;
  localparam int SUM_W     = 10;
  localparam int SQ_W      = 2 * SUM_W;
  localparam int MAG_W     = SQ_W + 1;
  localparam int THR_P1_W  = CFG_W + 1;
  localparam int LIM_W     = 2 * THR_P1_W;
  localparam int LINE_W    = 2 * PIX_W;

  localparam logic [CFG_W-1:0] HEIGHT_MAX    = 11'd1024;
  localparam logic [CFG_W-1:0] SIZE_MIN      = 11'd3;
  localparam logic [CFG_W-1:0] THR_RESET     = 11'd100;
  localparam logic [CFG_W-1:0] WIDTH_RESET   = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET  = 11'd1024;
  localparam logic [PIX_W-1:0] EDGE_LEVEL    = 8'd255;
  localparam logic [PIX_W-1:0] NO_EDGE_LEVEL = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } px_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             last_of_frame;
  } res_t;

  typedef struct packed {
    logic [SUM_W-1:0] left;
    logic [SUM_W-1:0] right;
    logic [SUM_W-1:0] top;
    logic [SUM_W-1:0] bottom;
    logic             last;
  } grad_in_t;

endpackage

@@ rtl/core/pwt_line_mem.sv @@
// Line store memory: one entry per column holding the upper and middle rows.
// Synchronous write, registered read. Uses pwt_pkg.
module pwt_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [pwt_pkg::LINE_W-1:0]        wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [pwt_pkg::LINE_W-1:0]        rd_data
);
  import pwt_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/pwt_grad.sv @@
// Gradient and threshold pipeline: column/row sums in, absolute differences,
// squares, magnitude compare, output register. Uses pwt_pkg.
module pwt_grad (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  pwt_pkg::grad_in_t           s_data,
  input  logic [pwt_pkg::LIM_W-1:0]   lim,
  output logic                        res_valid,
  input  logic                        res_ready,
  output pwt_pkg::res_t               res_data
);
  import pwt_pkg::*;

  logic             c_valid;
  grad_in_t         c_data;
  logic             d_valid;
  logic [SUM_W-1:0] d_dx;
  logic [SUM_W-1:0] d_dy;
  logic             d_last;
  logic             e_valid;
  logic [SQ_W-1:0]  e_sx;
  logic [SQ_W-1:0]  e_sy;
  logic             e_last;

  logic             o_free;
  logic             e_free;
  logic             d_free;
  logic [SUM_W-1:0] dx_next;
  logic [SUM_W-1:0] dy_next;
  logic [MAG_W-1:0] mag2;
  res_t             o_next;

  assign o_free  = !res_valid || res_ready;
  assign e_free  = !e_valid || o_free;
  assign d_free  = !d_valid || e_free;
  assign s_ready = !c_valid || d_free;

  always_comb begin
    dx_next = (c_data.right >= c_data.left) ? c_data.right - c_data.left
                                            : c_data.left - c_data.right;
    dy_next = (c_data.bottom >= c_data.top) ? c_data.bottom - c_data.top
                                            : c_data.top - c_data.bottom;
    mag2 = {1'b0, e_sx} + {1'b0, e_sy};
    o_next.edge_value    = (LIM_W'(mag2) >= lim) ? EDGE_LEVEL : NO_EDGE_LEVEL;
    o_next.last_of_frame = e_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s_ready) c_valid <= s_valid;
      if (d_free) d_valid <= c_valid;
      if (e_free) e_valid <= d_valid;
      if (o_free) res_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      c_data <= s_data;
    end
    if (d_free && c_valid) begin
      d_dx   <= dx_next;
      d_dy   <= dy_next;
      d_last <= c_data.last;
    end
    if (e_free && d_valid) begin
      e_sx   <= d_dx * d_dx;
      e_sy   <= d_dy * d_dy;
      e_last <= d_last;
    end
    if (o_free && e_valid) begin
      res_data <= o_next;
    end
  end

endmodule

@@ rtl/core/prewitt_edge_threshold.sv @@
// Top level of the Prewitt edge threshold block: configuration registers,
// raster counters, line store access, 3x3 window. Uses pwt_pkg, pwt_line_mem,
// pwt_grad.
//
//   channel  direction  handshake            payload
//   px       in         px_valid / px_ready  px_data   (pixel, frame_start)
//   res      out        res_valid / res_ready res_data (edge_value, last_of_frame)
//   cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per cycle sustained unless res_ready stalls the pipeline; a result passes the read stage,
// then the gradient input, difference, square and output registers. The line store is read as a pixel is
// taken and written back as it advances; a read that meets the write-back of its column takes the written data.
// Reset clears counters, window and pipeline; the line store is not cleared.
// A stalled result holds its register; earlier stages keep accepting into
// empty slots behind it.
module prewitt_edge_threshold #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            px_valid,
  output logic                            px_ready,
  input  pwt_pkg::px_t                    px_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output pwt_pkg::res_t                   res_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pwt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwt_pkg::CFG_W-1:0]       cfg_data
);
  import pwt_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int XW = (WW > CFG_W) ? WW : CFG_W;

  logic [CFG_W-1:0]    threshold;
  logic [CFG_W-1:0]    image_width;
  logic [CFG_W-1:0]    image_height;
  logic [LIM_W-1:0]    lim;
  logic [THR_P1_W-1:0] thr_p1;

  logic [CW-1:0]       col;
  logic [ROW_W-1:0]    row;
  logic [CW-1:0]       col_next;
  logic [ROW_W-1:0]    row_next;

  logic [XW-1:0]       w_raw;
  logic [WW-1:0]       w_eff;
  logic [CFG_W-1:0]    h_eff;
  logic [CW-1:0]       col0;
  logic [CFG_W-1:0]    row0;
  logic [CW-1:0]       cur_col;
  logic [CFG_W-1:0]    row1;
  logic [CFG_W-1:0]    cur_row;
  logic [WW-1:0]       col_inc;
  logic [CFG_W-1:0]    row_inc;
  logic                cur_produce;
  logic                cur_last;

  logic                px_acc;
  logic                b_valid;
  logic [CW-1:0]       b_addr;
  logic [PIX_W-1:0]    b_px;
  logic                b_produce;
  logic                b_last;
  logic                fwd_q;
  logic [LINE_W-1:0]   fwd_data;
  logic                b_adv;
  logic                c_free;

  logic                wr_en;
  logic [LINE_W-1:0]   wr_data;
  logic [LINE_W-1:0]   mem_rd;
  logic [LINE_W-1:0]   rd_cur;
  logic [PIX_W-1:0]    up_px;
  logic [PIX_W-1:0]    mid_px;

  logic [2:0][2:0][PIX_W-1:0] win;
  grad_in_t            g_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THR_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign thr_p1 = {1'b0, threshold} + THR_P1_W'(1);

  always_ff @(posedge clk) begin
    lim <= thr_p1 * thr_p1;
  end

  always_comb begin
    w_raw = XW'(image_width);
    if (w_raw < XW'(SIZE_MIN)) begin
      w_eff = WW'(SIZE_MIN);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw[WW-1:0];
    end
    if (image_height < SIZE_MIN) begin
      h_eff = SIZE_MIN;
    end else if (image_height > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = image_height;
    end

    col0 = px_data.frame_start ? '0 : col;
    row0 = px_data.frame_start ? '0 : CFG_W'(row);
    if ({1'b0, col0} >= w_eff) begin
      cur_col = '0;
      row1    = row0 + CFG_W'(1);
    end else begin
      cur_col = col0;
      row1    = row0;
    end
    cur_row = (row1 >= h_eff) ? '0 : row1;

    col_inc = {1'b0, cur_col} + WW'(1);
    row_inc = cur_row + CFG_W'(1);
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = cur_row[ROW_W-1:0];
    end

    cur_produce = (cur_row >= CFG_W'(2)) && (cur_col >= CW'(2));
    cur_last    = (cur_row == h_eff - CFG_W'(1)) &&
                  ({1'b0, cur_col} == w_eff - WW'(1));
  end

  assign px_ready = !b_valid || c_free;
  assign px_acc   = px_valid && px_ready;
  assign b_adv    = b_valid && c_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      b_valid <= 1'b0;
    end else begin
      if (px_acc) begin
        col <= col_next;
        row <= row_next;
      end
      if (px_ready) b_valid <= px_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (px_acc) begin
      b_addr    <= cur_col;
      b_px      <= px_data.pixel;
      b_produce <= cur_produce;
      b_last    <= cur_last;
      fwd_q     <= wr_en && (b_addr == cur_col);
      fwd_data  <= wr_data;
    end
  end

  assign rd_cur  = fwd_q ? fwd_data : mem_rd;
  assign up_px   = rd_cur[LINE_W-1:PIX_W];
  assign mid_px  = rd_cur[PIX_W-1:0];
  assign wr_en   = b_adv;
  assign wr_data = {mid_px, b_px};

  pwt_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b_addr),
    .wr_data (wr_data),
    .rd_en   (px_acc),
    .rd_addr (cur_col),
    .rd_data (mem_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (b_adv) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= up_px;
      win[1][2] <= mid_px;
      win[2][2] <= b_px;
    end
  end

  always_comb begin
    g_in.left   = SUM_W'(win[0][1]) + SUM_W'(win[1][1]) + SUM_W'(win[2][1]);
    g_in.right  = SUM_W'(up_px) + SUM_W'(mid_px) + SUM_W'(b_px);
    g_in.top    = SUM_W'(win[0][1]) + SUM_W'(win[0][2]) + SUM_W'(up_px);
    g_in.bottom = SUM_W'(win[2][1]) + SUM_W'(win[2][2]) + SUM_W'(b_px);
    g_in.last   = b_last;
  end

  pwt_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (b_adv && b_produce),
    .s_ready   (c_free),
    .s_data    (g_in),
    .lim       (lim),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

`ifndef NO_ASSERTIONS
  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    px_acc && wr_en && (b_addr == cur_col) |=> fwd_q)
    else $error("line store read missed write-back of the same column");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    px_acc |=> b_valid)
    else $error("accepted transaction did not reach the read stage");

  a_win_hold: assert property (@(posedge clk) disable iff (rst)
    !b_adv |=> $stable(win))
    else $error("window moved without an advancing transaction");
`endif

endmodule
